/* design/aarch64_relocation_patcher_core_defines.svh */
// Assertion macros shared by the relocation patcher checker.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef AARCH64_RELOCATION_PATCHER_CORE_DEFINES_SVH
`define AARCH64_RELOCATION_PATCHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ARP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("relocation patcher check failed");

// Next-cycle implication, disabled while reset is asserted
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("relocation patcher check failed");

`endif

/* design/arp_pkg.sv */
// Package for the AArch64 relocation patcher: kind codes, field masks, beat types.
// No dependencies.
`timescale 1ns / 1ps

package arp_pkg;

    // Relocation kinds
    localparam logic [2:0] KIND_REL26 = 3'd0;
    localparam logic [2:0] KIND_REL19 = 3'd1;
    localparam logic [2:0] KIND_ADRP  = 3'd2;
    localparam logic [2:0] KIND_ADR   = 3'd3;
    localparam logic [2:0] KIND_REL14 = 3'd4;
    localparam logic [2:0] KIND_IMM12 = 3'd5;
    localparam logic [2:0] KIND_REL64 = 3'd6;

    // Field masks within the instruction word
    localparam logic [31:0] MASK_REL26 = 32'h03ff_ffff;
    localparam logic [31:0] MASK_REL19 = 32'h00ff_ffe0;
    localparam logic [31:0] MASK_REL14 = 32'h0007_ffe0;
    localparam logic [31:0] MASK_IMM12 = 32'h003f_fc00;

    // Request beat
    typedef struct packed {
        logic [2:0]         kind;
        logic [63:0]        old_word;
        logic signed [63:0] displacement;
        logic [63:0]        site_address;
    } arp_req_t;

    // Result beat
    typedef struct packed {
        logic [63:0] new_word;
        logic        is_wide;
    } arp_rsp_t;

endpackage

/* design/arp_if.sv */
// Valid/ready channel interfaces for the relocation patcher request and result beats.
// No dependencies.
`timescale 1ns / 1ps

interface arp_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [63:0]        old_word;
    logic signed [63:0] displacement;
    logic [63:0]        site_address;

    modport source (output valid, output kind, output old_word, output displacement,
                    output site_address, input ready);
    modport sink   (input valid, input kind, input old_word, input displacement,
                    input site_address, output ready);
endinterface

interface arp_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] new_word;
    logic        is_wide;

    modport source (output valid, output new_word, output is_wide, input ready);
    modport sink   (input valid, input new_word, input is_wide, output ready);
endinterface

/* design/aarch64_relocation_patcher_core.sv */
// AArch64 relocation patcher: input register, patch logic, result register.
// Throughput: one beat per cycle while the result is not stalled, set by the single
// pass through the patch unit between the two registers.
// Reset (rst_n, asynchronous, active low) empties both stages; payload is not reset.
// Depends on arp_pkg, arp_if and arp_patch_unit.
`timescale 1ns / 1ps

module aarch64_relocation_patcher_core
    import arp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    arp_req_if.sink  request,
    arp_rsp_if.source result
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    arp_req_t s1_req_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    arp_rsp_t out_rsp_reg;
    arp_rsp_t patched;
    logic     out_free;
    logic     s1_free;
    logic     accept;

    // Stall chain: a stage takes a beat when it is empty or moving on
    assign out_free      = !out_valid_reg || result.ready;
    assign s1_free       = !s1_valid_reg || out_free;
    assign request.ready = s1_free;
    assign accept        = request.valid && s1_free;

    assign s1_valid_next  = s1_free ? request.valid : s1_valid_reg;
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    arp_patch_unit u_patch (
        .req (s1_req_reg),
        .rsp (patched)
    );

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg.kind         <= request.kind;
            s1_req_reg.old_word     <= request.old_word;
            s1_req_reg.displacement <= request.displacement;
            s1_req_reg.site_address <= request.site_address;
        end
        if (out_free && s1_valid_reg)
        begin
            out_rsp_reg <= patched;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.new_word = out_rsp_reg.new_word;
    assign result.is_wide  = out_rsp_reg.is_wide;

endmodule

/* design/arp_patch_unit.sv */
// Combinational patch datapath: applies one relocation to one word.
// Depends on arp_pkg.
`timescale 1ns / 1ps

module arp_patch_unit
    import arp_pkg::*;
(
    input  arp_req_t req,
    output arp_rsp_t rsp
);

    logic [31:0] op;
    logic [63:0] disp_u;
    logic [25:0] sum26;
    logic [23:0] sum19;
    logic [18:0] sum14;
    logic [63:0] site_sum;
    logic [20:0] pages;
    logic [20:0] adr_add;
    logic [20:0] imm21;
    logic [31:0] adr_word;
    logic [11:0] f12;
    logic [63:0] wide_sum;

    assign op     = req.old_word[31:0];
    assign disp_u = $unsigned(req.displacement);

    // Branch and load-literal fields: only the bits up to the field top matter
    assign sum26 = op[25:0] + disp_u[27:2];
    assign sum19 = op[23:0] + {disp_u[20:0], 3'b000};
    assign sum14 = op[18:0] + {disp_u[15:0], 3'b000};

    // Target address, shared by adrp and imm12
    assign site_sum = req.site_address + disp_u;

    // Page difference, wraps within the 21-bit field
    assign pages   = site_sum[32:12] - req.site_address[32:12];
    assign adr_add = (req.kind == KIND_ADRP) ? pages : disp_u[20:0];

    // Split immediate: immhi at 23:5, immlo at 30:29
    assign imm21 = {op[23:5], op[30:29]} + adr_add;
    always_comb
    begin
        adr_word        = op;
        adr_word[23:5]  = imm21[20:2];
        adr_word[30:29] = imm21[1:0];
    end

    // imm12: absolute when the target is zero, else add into the field
    assign f12 = (site_sum == 64'd0) ? disp_u[11:0] : (op[21:10] + site_sum[11:0]);

    assign wide_sum = req.old_word + disp_u;

    // Result select
    always_comb
    begin
        rsp.is_wide  = 1'b0;
        rsp.new_word = {32'd0, op};
        unique case (req.kind)
            KIND_REL26: rsp.new_word = {32'd0, (op & ~MASK_REL26) | {6'd0, sum26}};
            KIND_REL19: rsp.new_word = {32'd0, (op & ~MASK_REL19)
                                       | ({8'd0, sum19} & MASK_REL19)};
            KIND_REL14: rsp.new_word = {32'd0, (op & ~MASK_REL14)
                                       | ({13'd0, sum14} & MASK_REL14)};
            KIND_ADRP,
            KIND_ADR:   rsp.new_word = {32'd0, adr_word};
            KIND_IMM12: rsp.new_word = {32'd0, (op & ~MASK_IMM12) | {10'd0, f12, 10'd0}};
            KIND_REL64:
            begin
                rsp.new_word = wide_sum;
                rsp.is_wide  = 1'b1;
            end
            default:    rsp.new_word = {32'd0, op};
        endcase
    end

endmodule

/* design/arp_checker.sv */
// Port-level checker for the relocation patcher, bound to the top level.
// Depends on aarch64_relocation_patcher_core_defines.svh.
`timescale 1ns / 1ps
`include "aarch64_relocation_patcher_core_defines.svh"

module arp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [63:0] res_new_word,
    input logic        res_is_wide
);

    // A stalled result beat holds
    `ARP_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_new_word) && $stable(res_is_wide))

    // Narrow results carry a zero upper half
    `ARP_ASSERT_IMPLY(a_narrow_upper, clk, rst_n, res_valid && !res_is_wide, res_new_word[63:32] == 32'd0)

    // Back-pressure only comes from a stalled result
    `ARP_ASSERT_IMPLY(a_ready_cause, clk, rst_n, !req_ready, res_valid && !res_ready)

    // A new result follows an accepted request beat, through the input and result registers
    `ARP_ASSERT_IMPLY(a_res_source, clk, rst_n, $rose(res_valid), $past(req_valid && req_ready, 2))

endmodule

bind aarch64_relocation_patcher_core arp_checker u_arp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (request.valid),
    .req_ready    (request.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_new_word (result.new_word),
    .res_is_wide  (result.is_wide)
);
